/* hdl/iirdf_pkg.sv */
// Shared types, register indexes and coefficient helpers for the Q15 IIR filter.
// Used by iirdf_mac and iir_direct_form_q15_filter_top; depends on nothing else.
package iirdf_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_FF_COEF_LOW  = 3'd0;
    localparam logic [2:0] CFG_FF_COEF_HIGH = 3'd1;
    localparam logic [2:0] CFG_FB_COEF_LOW  = 3'd2;
    localparam logic [2:0] CFG_FB_COEF_HIGH = 3'd3;
    localparam logic [2:0] CFG_FF_TAP_COUNT = 3'd4;
    localparam logic [2:0] CFG_FB_TAP_COUNT = 3'd5;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int COEF_NUM = 8;   // coefficients held per bank

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SAMPLE_W-1:0] coef_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FF,
        ST_FF_WAIT,
        ST_GAIN,
        ST_GAIN_WAIT,
        ST_FB,
        ST_FB_WAIT,
        ST_DONE
    } state_t;

    // Operation of the shared multiply unit
    typedef enum logic [1:0] {
        MAC_ADD,
        MAC_SUB,
        MAC_GAIN
    } mac_op_t;

    typedef struct packed {
        logic    clear;   // zero the accumulator
        logic    issue;   // start a multiply this cycle
        mac_op_t op;
    } mac_ctl_t;

    // Coefficient k of a 128-bit bank; taps beyond eight read as zero
    function automatic coef_t coef_sel(input logic [127:0] bank, input logic [4:0] k);
        logic [6:0] base;
        base = {k[2:0], 4'b0000};
        if (k < 5'(COEF_NUM)) begin
            return bank[base +: SAMPLE_W];
        end
        return '0;
    endfunction

endpackage

/* hdl/iir_direct_form_q15_filter_top.sv */
// Top level of the direct-form I IIR filter on signed Q15 samples.
// Holds configuration, delay lines and sequencer; uses iirdf_pkg and iirdf_mac.
//
// Usage:
//   Input channel s_valid/s_ready/s_sample_in takes one Q15 sample per
//   transaction. Output channel m_valid/m_ready/m_sample_out returns one
//   filtered sample per input transaction, in order.
//   Configuration: cfg_wr_en/cfg_index/cfg_wr_data write a register
//   (0..3 coefficient banks, 4 and 5 tap counts); write only while idle.
//   Indexes 6 and 7 are ignored.
//   One shared multiplier walks the taps: na feedforward products, the gain
//   product and nb-1 feedback products, with a pipeline drain state after
//   each group. The next sample can be taken in the cycle after the result
//   is loaded, so a sample is taken only once the last one is through.
//   The multiplier's two-stage pipeline and the tap counts set the latency.
//   Reset clears both delay lines, coefficients to zero and tap counts to one.
//   A result waits in the output register while m_ready is low; a new sample
//   is still accepted, and its result is held back until the register frees.
module iir_direct_form_q15_filter_top
    import iirdf_pkg::*;
#(
    parameter int MAX_TAPS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_wr_data,
    // input samples
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_sample_in,
    // output samples
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_sample_out
);

    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    // Configuration registers
    logic [63:0] ff_lo_reg, ff_hi_reg, fb_lo_reg, fb_hi_reg;
    logic [3:0]  ff_cnt_reg, fb_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_lo_reg  <= '0;
            ff_hi_reg  <= '0;
            fb_lo_reg  <= '0;
            fb_hi_reg  <= '0;
            ff_cnt_reg <= 4'd1;
            fb_cnt_reg <= 4'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FF_COEF_LOW:  ff_lo_reg  <= cfg_wr_data;
                CFG_FF_COEF_HIGH: ff_hi_reg  <= cfg_wr_data;
                CFG_FB_COEF_LOW:  fb_lo_reg  <= cfg_wr_data;
                CFG_FB_COEF_HIGH: fb_hi_reg  <= cfg_wr_data;
                CFG_FF_TAP_COUNT: ff_cnt_reg <= cfg_wr_data[3:0];
                CFG_FB_TAP_COUNT: fb_cnt_reg <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    // Tap counts clamped to the delay line depth
    logic [CW-1:0] na, nb;
    assign na = (5'(ff_cnt_reg) > 5'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(ff_cnt_reg);
    assign nb = (5'(fb_cnt_reg) > 5'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(fb_cnt_reg);

    // Sequencer registers
    state_t        state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          last_ff, last_fb;

    logic          accept;
    logic          out_load;
    logic          m_valid_reg, m_valid_next;
    sample_t       m_sample_reg;

    sample_t       in_dly_reg  [MAX_TAPS];
    sample_t       out_dly_reg [MAX_TAPS];

    mac_ctl_t            mac_ctl;
    logic signed [16:0]  op_a;
    logic signed [15:0]  op_b;
    logic [ACC_W-1:0]    acc;
    sample_t             dly_sel;
    coef_t               coef_ff, coef_fb;

    assign accept  = s_valid && s_ready;
    assign last_ff = ({1'b0, idx_reg} + 1'b1) >= {1'b0, na};
    assign last_fb = ({1'b0, idx_reg} + 1'b1) >= {1'b0, nb};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (accept) state_next = (na != '0) ? ST_FF : ST_GAIN;
            ST_FF:        if (last_ff) state_next = ST_FF_WAIT;
            ST_FF_WAIT:   state_next = ST_GAIN;
            ST_GAIN:      state_next = ST_GAIN_WAIT;
            ST_GAIN_WAIT: state_next = (nb > CW'(1)) ? ST_FB : ST_DONE;
            ST_FB:        if (last_fb) state_next = ST_FB_WAIT;
            ST_FB_WAIT:   state_next = ST_DONE;
            ST_DONE:      if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Operand selection for the shared unit
    assign coef_ff = coef_sel({ff_hi_reg, ff_lo_reg}, 5'(idx_reg));
    assign coef_fb = coef_sel({fb_hi_reg, fb_lo_reg}, 5'(idx_reg));
    assign dly_sel = (state_reg == ST_FB) ? out_dly_reg[idx_reg[IW-1:0]]
                                          : in_dly_reg[idx_reg[IW-1:0]];

    // Outputs of the sequencer
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        out_load      = 1'b0;
        idx_next      = idx_reg;
        mac_ctl.clear = 1'b0;
        mac_ctl.issue = 1'b0;
        mac_ctl.op    = MAC_ADD;
        op_a          = {dly_sel[15], dly_sel};
        op_b          = coef_ff;
        unique case (state_reg)
            ST_IDLE: begin
                mac_ctl.clear = accept;
                idx_next      = '0;
            end
            ST_FF: begin
                mac_ctl.issue = 1'b1;
                idx_next      = idx_reg + 1'b1;
            end
            ST_GAIN: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.op    = MAC_GAIN;
                op_a          = acc[ACC_W-1:15];
                op_b          = coef_fb;       // idx is zero here: gain b0
                idx_next      = CW'(1);
            end
            ST_FB: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.op    = MAC_SUB;
                op_b          = coef_fb;
                idx_next      = idx_reg + 1'b1;
            end
            ST_FF_WAIT: idx_next = '0;
            ST_DONE:    out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Delay lines: shift active entries on accept, store result on load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                in_dly_reg[i]  <= '0;
                out_dly_reg[i] <= '0;
            end
        end else begin
            if (accept) begin
                in_dly_reg[0] <= s_sample_in;
                for (int i = 1; i < MAX_TAPS; i++) begin
                    if (CW'(i) < na) in_dly_reg[i] <= in_dly_reg[i-1];
                    if (CW'(i) < nb) out_dly_reg[i] <= out_dly_reg[i-1];
                end
            end
            if (out_load) begin
                out_dly_reg[0] <= acc[ACC_W-1:16];
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (out_load) begin
            m_sample_reg <= acc[ACC_W-1:16];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

    iirdf_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .acc     (acc)
    );

`ifndef SYNTHESIS
    // Only one sample in flight: ready drops right after a transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample accepted while busy");

    // A result appears only when the sequencer finishes
    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside completion state");

    // Feedback never reads the gain slot
    a_fb_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FB) |-> (idx_reg != '0))
        else $error("feedback tap index zero");

    // Completion waits for a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid && !m_ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");
`endif

endmodule

/* hdl/iirdf_mac.sv */
// Shared multiply unit with saturating Q15 accumulate for the IIR filter.
// Two stages: registered 17x16 product, then accumulate. Depends on iirdf_pkg.
module iirdf_mac
    import iirdf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mac_ctl_t             ctl,
    input  logic signed [16:0]   op_a,
    input  logic signed [15:0]   op_b,
    output logic [ACC_W-1:0]     acc
);

    logic signed [32:0] prod_reg;
    mac_op_t            op_reg;
    logic               vld_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;

    logic [33:0]        dbl;
    logic [ACC_W-1:0]   dbl_sat;
    logic [ACC_W:0]     sum;

    // Stage 1: product register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            op_reg  <= MAC_ADD;
        end else begin
            vld_reg <= ctl.issue;
            op_reg  <= ctl.op;
        end
        prod_reg <= op_a * op_b;
    end

    // Stage 2: doubled product saturated to 32 bits, saturating add/sub, gain load
    always_comb begin
        dbl = {prod_reg, 1'b0};
        if (dbl[33:31] == 3'b000 || dbl[33:31] == 3'b111) begin
            dbl_sat = dbl[ACC_W-1:0];
        end else if (dbl[33]) begin
            dbl_sat = 32'h8000_0000;
        end else begin
            dbl_sat = 32'h7FFF_FFFF;
        end

        if (op_reg == MAC_SUB) begin
            sum = {acc_reg[ACC_W-1], acc_reg} - {dbl_sat[ACC_W-1], dbl_sat};
        end else begin
            sum = {acc_reg[ACC_W-1], acc_reg} + {dbl_sat[ACC_W-1], dbl_sat};
        end

        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (vld_reg) begin
            if (op_reg == MAC_GAIN) begin
                acc_next = prod_reg[ACC_W-1:0];       // gain wraps modulo 2^32
            end else if (sum[ACC_W] != sum[ACC_W-1]) begin
                acc_next = sum[ACC_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                acc_next = sum[ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the direct-form I Q15 IIR filter top level.
// Predicts each output sample in place; needs iirdf_pkg and the filter RTL.
module tb;
    import iirdf_pkg::*;

    localparam int TAP_MAX         = 8;
    localparam int RESET_CYCLES    = 7;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RAND_PHASES     = 8;
    localparam int PHASE_ITEMS     = 166;

    localparam longint ACC_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint ACC_MIN = -64'sh0000_0000_8000_0000;

    // indexes the block decodes to nothing
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    typedef enum logic {ENT_SAMPLE, ENT_REG} entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        sample_t     sample;
        logic [2:0]  idx;
        logic [63:0] data;
    } feed_entry_t;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_PATTERN} rx_mode_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [2:0]          cfg_index   = '0;
    logic [63:0]         cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic signed [15:0]  s_sample_in = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic signed [15:0]  m_sample_out;

    feed_entry_t input_feed_q [$];
    sample_t     expected_out_q [$];
    int          err_count = 0;

    // predictor copy of configuration and delay lines
    logic [63:0] ff_lo_m, ff_hi_m, fb_lo_m, fb_hi_m;
    logic [3:0]  ff_cnt_m, fb_cnt_m;
    sample_t     x_hist [TAP_MAX];
    sample_t     y_hist [TAP_MAX];

    iir_direct_form_q15_filter_top #(
        .MAX_TAPS(TAP_MAX)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample_out(m_sample_out)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clip32(longint v);
        if (v > ACC_MAX) return ACC_MAX;
        if (v < ACC_MIN) return ACC_MIN;
        return v;
    endfunction

    // doubled Q15 product, saturated to 32 bits
    function automatic longint qmul(sample_t a, sample_t b);
        return clip32(2 * longint'(a) * longint'(b));
    endfunction

    function automatic sample_t tap_coef(logic [63:0] lo, logic [63:0] hi, int k);
        if (k < 4) return lo[16*k +: 16];
        if (k < 8) return hi[16*(k-4) +: 16];
        return '0;
    endfunction

    function automatic void load_setting(logic [2:0] idx, logic [63:0] d);
        case (idx)
            CFG_FF_COEF_LOW:  ff_lo_m  = d;
            CFG_FF_COEF_HIGH: ff_hi_m  = d;
            CFG_FB_COEF_LOW:  fb_lo_m  = d;
            CFG_FB_COEF_HIGH: fb_hi_m  = d;
            CFG_FF_TAP_COUNT: ff_cnt_m = d[3:0];
            CFG_FB_TAP_COUNT: fb_cnt_m = d[3:0];
            default: ;
        endcase
    endfunction

    // one filter step: shift histories, MAC forward, gain, subtract feedback
    function automatic sample_t filter_step(sample_t x);
        int      na;
        int      nb;
        longint  acc;
        longint  gained;
        sample_t y;
        na = (ff_cnt_m > TAP_MAX) ? TAP_MAX : int'(ff_cnt_m);
        nb = (fb_cnt_m > TAP_MAX) ? TAP_MAX : int'(fb_cnt_m);
        for (int i = na; i >= 2; i--) x_hist[i-1] = x_hist[i-2];
        for (int i = nb; i >= 2; i--) y_hist[i-1] = y_hist[i-2];
        x_hist[0] = x;
        acc = 0;
        for (int i = 0; i < na; i++)
            acc = clip32(acc + qmul(tap_coef(ff_lo_m, ff_hi_m, i), x_hist[i]));
        // floor shift, then gain wrapping to 32 bits
        gained = (acc >>> 15) * longint'(tap_coef(fb_lo_m, fb_hi_m, 0));
        acc = longint'($signed(gained[31:0]));
        for (int i = 1; i < nb; i++)
            acc = clip32(acc - qmul(tap_coef(fb_lo_m, fb_hi_m, i), y_hist[i]));
        y = acc[31:16];
        y_hist[0] = y;
        return y;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic void push_sample(sample_t v);
        feed_entry_t e;
        e.kind = ENT_SAMPLE;
        e.sample = v;
        e.idx = '0;
        e.data = '0;
        input_feed_q.push_back(e);
    endfunction

    function automatic void push_reg(logic [2:0] idx, logic [63:0] d);
        feed_entry_t e;
        e.kind = ENT_REG;
        e.sample = '0;
        e.idx = idx;
        e.data = d;
        input_feed_q.push_back(e);
    endfunction

    // four packed Q15 coefficients: full range, small, mid or extremes
    function automatic logic [63:0] rand_coef_word();
        logic [63:0] w;
        int          mode;
        int          c;
        mode = $urandom_range(0, 3);
        w = {$urandom(), $urandom()};
        for (int k = 0; k < 4; k++) begin
            case (mode)
                1: begin
                    c = int'($urandom_range(0, 8190)) - 4095;
                    w[16*k +: 16] = 16'(c);
                end
                2: begin
                    c = int'($urandom_range(0, 32766)) - 16383;
                    w[16*k +: 16] = 16'(c);
                end
                3: begin
                    case ($urandom_range(0, 3))
                        0: w[16*k +: 16] = 16'h8000;
                        1: w[16*k +: 16] = 16'h7FFF;
                        2: w[16*k +: 16] = 16'h0000;
                        default: w[16*k +: 16] = 16'hFFFF;
                    endcase
                end
                default: ;
            endcase
        end
        return w;
    endfunction

    // tap count with junk in the unused upper bits; mostly 1..8
    function automatic logic [63:0] rand_count_word();
        logic [63:0] w;
        int          r;
        w = {$urandom(), $urandom()};
        r = $urandom_range(0, 19);
        if (r == 0) w[3:0] = 4'd0;
        else if (r == 1) w[3:0] = 4'($urandom_range(9, 15));
        else w[3:0] = 4'($urandom_range(1, 8));
        return w;
    endfunction

    function automatic sample_t rand_sample();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh0000;
                default: return -16'sd1;
            endcase
        end
        if (r < 3) begin
            v = int'($urandom_range(0, 512)) - 256;
            return sample_t'(v);
        end
        return sample_t'($urandom());
    endfunction

    // ---------------------------------------------------------------- driver

    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        logic        nxt_valid;
        logic        nxt_wr;
        feed_entry_t ent;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_sample_in <= '0;
            cfg_wr_en   <= 1'b0;
            cfg_index   <= '0;
            cfg_wr_data <= '0;
            burst_left = 1;
            gap_left   = 0;
            ff_lo_m  = '0;
            ff_hi_m  = '0;
            fb_lo_m  = '0;
            fb_hi_m  = '0;
            ff_cnt_m = 4'd1;
            fb_cnt_m = 4'd1;
            for (int i = 0; i < TAP_MAX; i++) begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
        end else begin
            nxt_valid = s_valid && !s_ready;
            nxt_wr    = 1'b0;
            if (s_valid && s_ready)
                expected_out_q.push_back(filter_step(s_sample_in));
            if (!nxt_valid && input_feed_q.size() != 0) begin
                if (input_feed_q[0].kind == ENT_REG) begin
                    // registers change only once every result is out
                    if (expected_out_q.size() == 0) begin
                        ent = input_feed_q.pop_front();
                        load_setting(ent.idx, ent.data);
                        cfg_index   <= ent.idx;
                        cfg_wr_data <= ent.data;
                        nxt_wr = 1'b1;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    ent = input_feed_q.pop_front();
                    s_sample_in <= ent.sample;
                    nxt_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                               : $urandom_range(0, 6);
                    end
                end
            end
            s_valid   <= nxt_valid;
            cfg_wr_en <= nxt_wr;
        end
    end

    // ---------------------------------------------------------------- monitor

    int       rx_count  = 0;
    int       hold_left = 0;
    int       win_left  = 0;
    int       pat_pos   = 0;
    rx_mode_t rx_mode   = RX_FREE;
    logic [7:0] rx_pattern = 8'hFF;

    always @(posedge aclk) begin
        sample_t want;
        logic    nxt_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                rx_count++;
                if (expected_out_q.size() == 0) begin
                    report_mismatch($sformatf("sample_out %0d with nothing pending",
                                              m_sample_out));
                end else begin
                    want = expected_out_q.pop_front();
                    if (m_sample_out !== want)
                        report_mismatch($sformatf("result %0d: sample_out %0d, want %0d",
                                                  rx_count, m_sample_out, want));
                end
                // long back-pressure so the block fills and stalls its input
                if (rx_count % 500 == 250) hold_left = HOLD_OFF_CYCLES;
            end
            if (win_left == 0) begin
                rx_mode    = rx_mode_t'($urandom_range(0, 3));
                rx_pattern = 8'($urandom());
                win_left   = $urandom_range(16, 96);
            end else begin
                win_left--;
            end
            pat_pos = (pat_pos + 1) % 8;
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:    nxt_ready = 1'b1;
                    RX_COIN:    nxt_ready = 1'($urandom_range(0, 1));
                    RX_SLOW:    nxt_ready = ($urandom_range(0, 3) == 0);
                    default:    nxt_ready = rx_pattern[pat_pos];
                endcase
            end
            m_ready <= nxt_ready;
        end
    end

    // ---------------------------------------------------------------- watchdog

    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        // eight taps a side, extreme coefficients and samples, saturating products
        push_reg(CFG_FF_COEF_LOW,  {16'h4000, 16'hC000, 16'h7FFF, 16'h8000});
        push_reg(CFG_FF_COEF_HIGH, {16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF});
        push_reg(CFG_FB_COEF_LOW,  {16'h0800, 16'hF800, 16'h2000, 16'h7FFF});
        push_reg(CFG_FB_COEF_HIGH, {16'h8000, 16'h7FFF, 16'h0100, 16'hFF00});
        push_reg(CFG_FF_TAP_COUNT, 64'd8);
        push_reg(CFG_FB_TAP_COUNT, 64'd8);
        push_sample(16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sh7FFF);
        push_sample(16'sh7FFF);
        push_sample(16'sh0000);
        push_sample(-16'sd1);
        push_sample(16'sd1);
        push_sample(16'sh5555);
        push_sample(-16'sh5556);

        // zero tap counts (upper bits ignored), spare indexes ignored
        push_reg(CFG_FF_TAP_COUNT, 64'hFFFF_FFFF_FFFF_FFF0);
        push_reg(CFG_FB_TAP_COUNT, 64'hFFFF_FFFF_FFFF_FFF0);
        push_reg(CFG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF);
        push_reg(CFG_SPARE_7, 64'h0000_0000_0000_0003);
        push_sample(16'sd12345);
        push_sample(16'sh8000);
        push_sample(16'sh7FFF);
        push_sample(-16'sd1);

        // counts above the maximum clamp; negative full-scale gain
        push_reg(CFG_FB_COEF_LOW,  {16'h1000, 16'hE000, 16'h4000, 16'h8000});
        push_reg(CFG_FF_TAP_COUNT, 64'd15);
        push_reg(CFG_FB_TAP_COUNT, 64'd9);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sd100);
        push_sample(-16'sd100);
        push_sample(16'sh7FFF);
        push_sample(16'sh0000);

        // random phases, each with a new random subset of settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            if ($urandom_range(0, 3) != 0) push_reg(CFG_FF_COEF_LOW,  rand_coef_word());
            if ($urandom_range(0, 3) != 0) push_reg(CFG_FF_COEF_HIGH, rand_coef_word());
            if ($urandom_range(0, 3) != 0) push_reg(CFG_FB_COEF_LOW,  rand_coef_word());
            if ($urandom_range(0, 3) != 0) push_reg(CFG_FB_COEF_HIGH, rand_coef_word());
            if ($urandom_range(0, 3) != 0) push_reg(CFG_FF_TAP_COUNT, rand_count_word());
            if ($urandom_range(0, 3) != 0) push_reg(CFG_FB_TAP_COUNT, rand_count_word());
            if ($urandom_range(0, 4) == 0)
                push_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                         {$urandom(), $urandom()});
            repeat (PHASE_ITEMS) push_sample(rand_sample());
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (input_feed_q.size() != 0 || s_valid || expected_out_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/iirdf_pkg.sv
hdl/iirdf_mac.sv
hdl/iir_direct_form_q15_filter_top.sv
test/tb.sv
